// ----- rtl/core/pvi_pkg.sv -----
// ----------------------------------------------------------------------------
// PID variable integral package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pvi_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int OUT_W       = 16;
   localparam int RSP_DATA_W  = 2 * OUT_W;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int BAND_W      = 16;
   localparam int DIV_STEPS   = 16;
   localparam int DIV_CNT_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATION_BAND = 3'd5;

   localparam logic [1:0] MUL_KI_MAG = 2'd0;
   localparam logic [1:0] MUL_WEIGHT = 2'd1;
   localparam logic [1:0] MUL_KP_ERR = 2'd2;
   localparam logic [1:0] MUL_KD_DER = 2'd3;

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       div_step;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       int_upd;
      logic       acc_add;
      logic       out_load;
   } pvi_cmd_type;

   typedef struct packed {
      logic div_done;
   } pvi_status_type;

endpackage

// ----- rtl/core/pid_variable_integral_core.sv -----
// ----------------------------------------------------------------------------
// PID controller with variable-speed integral
// Positional PID whose integral weight fades with the error magnitude.
//
//   Group   Direction  Content
//   req_    in         target, measured samples
//   rsp_    out        drive, integral term
//   csr_    in         gain, limit and band register writes
//
// An item passes from acceptance through a prepare step, the bit-serial weight
// divider, six steps on the shared multiplier and accumulator and a load of the
// result register. Input is taken again in the cycle after that load, so a new
// item starts only after the last one is loaded, and a result may wait on
// rsp_tready while the next item is processed.
// Reset clears the integral and the previous error and restores register defaults.
// ----------------------------------------------------------------------------
module pid_variable_integral_core #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // target, measured
   input  logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // drive, integral_term
   output logic [pvi_pkg::RSP_DATA_W-1:0]              rsp_tdata,
   input  logic                                        csr_wr_en,
   input  logic [pvi_pkg::CSR_INDEX_W-1:0]             csr_index,
   input  logic [pvi_pkg::CSR_DATA_W-1:0]              csr_wr_data
);
   import pvi_pkg::*;

   pvi_cmd_type    cmd;
   pvi_status_type status;
   logic [OUT_W-1:0] drive;
   logic [OUT_W-1:0] integral_term;

   pvi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pvi_datapath #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .target        (req_tdata[SAMPLE_WIDTH-1:0]),
      .measured      (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .cmd           (cmd),
      .status        (status),
      .drive         (drive),
      .integral_term (integral_term)
   );

   assign rsp_tdata = {integral_term, drive};

endmodule

// ----- rtl/core/pvi_ctrl.sv -----
// ----------------------------------------------------------------------------
// PID variable integral controller
// Sequences the divider, the shared multiplier and the result register.
// ----------------------------------------------------------------------------
module pvi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output pvi_pkg::pvi_cmd_type   cmd,
   input  pvi_pkg::pvi_status_type status
);
   import pvi_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREP = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_M2   = 4'd4;
   localparam logic [3:0] S_INT  = 4'd5;
   localparam logic [3:0] S_MP   = 4'd6;
   localparam logic [3:0] S_MD   = 4'd7;
   localparam logic [3:0] S_ADD  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KI_MAG;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_WEIGHT;
            state_in    = S_INT;
         end
         S_INT: begin
            cmd.int_upd = 1'b1;
            state_in    = S_MP;
         end
         S_MP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KP_ERR;
            state_in    = S_MD;
         end
         S_MD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KD_DER;
            cmd.acc_add = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.acc_add = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/pvi_datapath.sv -----
// ----------------------------------------------------------------------------
// PID variable integral datapath
// Holds the settings, error state, serial divider, shared multiplier,
// integral accumulator and result registers.
// ----------------------------------------------------------------------------
module pvi_datapath #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pvi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pvi_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic signed [SAMPLE_WIDTH-1:0]       target,
   input  logic signed [SAMPLE_WIDTH-1:0]       measured,
   input  pvi_pkg::pvi_cmd_type                 cmd,
   output pvi_pkg::pvi_status_type              status,
   output logic [pvi_pkg::OUT_W-1:0]            drive,
   output logic [pvi_pkg::OUT_W-1:0]            integral_term
);
   import pvi_pkg::*;

   localparam int EW  = SAMPLE_WIDTH + 1;
   localparam int DW  = SAMPLE_WIDTH + 2;
   localparam int CW  = (EW > BAND_W) ? EW : BAND_W;
   localparam int MAW = (DW > 33) ? DW : 33;
   localparam int MBW = GAIN_W + 1;
   localparam int PW  = MAW + MBW;
   localparam int IW  = LIMIT_W + 1 + FRACTION_BITS;
   localparam int ISW = ((IW > 33) ? IW : 33) + 1;
   localparam int AW  = PW + 2;

   logic [GAIN_W-1:0]  kp_ff;
   logic [GAIN_W-1:0]  ki_ff;
   logic [GAIN_W-1:0]  kd_ff;
   logic [LIMIT_W-1:0] ilim_ff;
   logic [LIMIT_W-1:0] olim_ff;
   logic [BAND_W-1:0]  band_ff;

   logic signed [EW-1:0]  err_ff;
   logic signed [EW-1:0]  prev_ff;
   logic signed [DW-1:0]  derr_ff;
   logic [BAND_W-1:0]     mag16_ff;
   logic                  neg_ff;
   logic                  use_int_ff;
   logic [BAND_W:0]       rem_ff;
   logic [BAND_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [IW-1:0]  isum_ff;
   logic signed [AW-1:0]  acc_ff;
   logic [OUT_W-1:0]      drive_ff;
   logic [OUT_W-1:0]      iterm_ff;

   logic [EW-1:0]         mag_c;
   logic [CW-1:0]         mag_ext;
   logic [BAND_W-1:0]     band_c;
   logic [BAND_W:0]       rem_shift;
   logic [BAND_W-1:0]     weight_c;
   logic signed [MAW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [PW-1:0]  prod_c;
   logic signed [ISW-1:0] inc_c;
   logic signed [ISW-1:0] isum_sum;
   logic signed [ISW-1:0] ilim_c;
   logic signed [ISW-1:0] isum_new;
   logic signed [AW-1:0]  acc_shift;
   logic signed [AW-1:0]  olim_c;
   logic signed [AW-1:0]  drive_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         ilim_ff <= '1;
         olim_ff <= '1;
         band_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:       kp_ff   <= csr_wr_data;
            CSR_INTEG_GAIN:      ki_ff   <= csr_wr_data;
            CSR_DERIV_GAIN:      kd_ff   <= csr_wr_data;
            CSR_INTEGRAL_LIMIT:  ilim_ff <= csr_wr_data[LIMIT_W-1:0];
            CSR_OUTPUT_LIMIT:    olim_ff <= csr_wr_data[LIMIT_W-1:0];
            CSR_SEPARATION_BAND: band_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign mag_c     = err_ff[EW-1] ? EW'(-err_ff) : EW'(err_ff);
   assign mag_ext   = CW'(mag_c);
   assign band_c    = (band_ff == '0) ? BAND_W'(1) : band_ff;
   assign rem_shift = {rem_ff[BAND_W-1:0], 1'b0};
   assign weight_c  = ~quo_ff + BAND_W'(1);
   assign status.div_done = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      case (cmd.mul_sel)
         MUL_KI_MAG: begin
            mul_a = MAW'(mag16_ff);
            mul_b = MBW'(ki_ff);
         end
         MUL_WEIGHT: begin
            mul_a = MAW'(prod_ff[31:0]);
            mul_b = MBW'(weight_c);
         end
         MUL_KP_ERR: begin
            mul_a = MAW'(err_ff);
            mul_b = MBW'(kp_ff);
         end
         default: begin
            mul_a = MAW'(derr_ff);
            mul_b = MBW'(kd_ff);
         end
      endcase
   end

   assign prod_c = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      inc_c = use_int_ff ? ISW'(prod_ff[47:16]) : '0;
      if (neg_ff) begin
         inc_c = -inc_c;
      end
      isum_sum = ISW'(isum_ff) + inc_c;
      ilim_c   = ISW'(ilim_ff) << FRACTION_BITS;
      if (isum_sum > ilim_c) begin
         isum_new = ilim_c;
      end else if (isum_sum < -ilim_c) begin
         isum_new = -ilim_c;
      end else begin
         isum_new = isum_sum;
      end
   end

   always_comb begin
      acc_shift = acc_ff >>> FRACTION_BITS;
      olim_c    = AW'(olim_ff);
      if (acc_shift > olim_c) begin
         drive_c = olim_c;
      end else if (acc_shift < -olim_c) begin
         drive_c = -olim_c;
      end else begin
         drive_c = acc_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         isum_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.prep) begin
            prev_ff    <= err_ff;
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         if (cmd.int_upd) begin
            isum_ff <= IW'(isum_new);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= EW'(target) - EW'(measured);
      end
      if (cmd.prep) begin
         neg_ff     <= err_ff[EW-1];
         mag16_ff   <= mag_ext[BAND_W-1:0];
         use_int_ff <= (mag_c != '0) && (mag_ext < CW'(band_c));
         derr_ff    <= DW'(err_ff) - DW'(prev_ff);
         rem_ff     <= {1'b0, mag_ext[BAND_W-1:0]};
         quo_ff     <= '0;
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, band_c}) begin
            rem_ff <= rem_shift - {1'b0, band_c};
            quo_ff <= {quo_ff[BAND_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[BAND_W-2:0], 1'b0};
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_c;
      end
      if (cmd.int_upd) begin
         acc_ff <= AW'(isum_new);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
      if (cmd.out_load) begin
         drive_ff <= OUT_W'(drive_c);
         iterm_ff <= isum_ff[IW-1:FRACTION_BITS];
      end
   end

   assign drive         = drive_ff;
   assign integral_term = iterm_ff;

endmodule
